// File: hw/rtl/rss_pkg.sv
// Types, constants and stencil helpers shared by the sharpen filter files.
`default_nettype none
package rss_pkg;

	localparam int MAX_LINE_WIDTH_DEF = 4096;
	localparam int QUEUE_DEPTH_DEF    = 4;
	localparam int MIN_DIM            = 3;
	localparam int MAX_HEIGHT         = 4096;
	localparam int POS_W              = 12;
	localparam int CFG_W              = 13;
	localparam int PIX_W              = 24;
	localparam int APB_AW             = 3;
	localparam int APB_DW             = 32;

	localparam logic [CFG_W-1:0] WIDTH_RST  = 13'd640;
	localparam logic [CFG_W-1:0] HEIGHT_RST = 13'd480;

	// register index, taken from paddr[2]
	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	// channel slots within a packed pixel
	localparam int CH_BLUE  = 0;
	localparam int CH_GREEN = 1;
	localparam int CH_RED   = 2;
	localparam int TAP_CENTER = 4;

	typedef struct packed {
		logic       frame_start;
		logic [7:0] red_in;
		logic [7:0] green_in;
		logic [7:0] blue_in;
	} pixel_t;

	typedef struct packed {
		logic [POS_W-1:0] out_row;
		logic [POS_W-1:0] out_col;
		logic [7:0]       red_out;
		logic [7:0]       green_out;
		logic [7:0]       blue_out;
		logic             frame_end;
	} result_t;

	// taps are column-major: k = column*3 + row
	typedef logic [8:0][PIX_W-1:0] window_t;

	typedef struct packed {
		logic [POS_W-1:0] row;
		logic [POS_W-1:0] col;
		logic             frame_end;
		window_t          win;
	} q_entry_t;

	typedef struct packed {
		logic     push;
		q_entry_t entry;
	} q_wr_t;

	typedef struct packed {
		logic     valid;
		q_entry_t entry;
	} q_rd_t;

	typedef struct packed {
		logic [POS_W-1:0] row;
		logic [POS_W-1:0] col;
		logic             frame_end;
		logic [2:0][7:0]  center;
		logic [2:0][10:0] nsum;
	} sums_t;

	function automatic logic [10:0] nbr_sum(input window_t win, input int ch);
		logic [10:0] s;
		s = '0;
		for (int k = 0; k < 9; k++) begin
			if (k != TAP_CENTER)
				s = s + {3'b000, win[k][ch*8 +: 8]};
		end
		return s;
	endfunction

	function automatic logic [7:0] sharpen_clamp(input logic [7:0] c, input logic [10:0] s);
		logic [11:0]        c9;
		logic signed [12:0] acc;
		c9  = {1'b0, c, 3'b000} + {4'b0000, c};
		acc = $signed({1'b0, c9}) - $signed({2'b00, s});
		if (acc >= 13'sd255)
			return 8'hFF;
		else if (acc <= 13'sd0)
			return 8'h00;
		else
			return acc[7:0];
	endfunction

endpackage
`default_nettype wire

// File: hw/rtl/rss_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module rss_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (re)
			rdata <= mem[raddr];
		if (we)
			mem[waddr] <= wdata;
	end

endmodule
`default_nettype wire

// File: hw/rtl/rss_front.sv
// Front end: raster position, line stores, 3x3 window, interior classification.
`default_nettype none
module rss_front
	import rss_pkg::*;
#(
	parameter int MAX_LINE_WIDTH = MAX_LINE_WIDTH_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             accept,
	input  wire pixel_t           pixel,
	input  wire logic [CFG_W-1:0] image_width,
	input  wire logic [CFG_W-1:0] image_height,
	output q_wr_t                 q_wr
);

	localparam int CW = $clog2(MAX_LINE_WIDTH);
	localparam int XW = (CW + 1 > 14) ? CW + 1 : 14;
	localparam int HW = 14;

	logic [CW-1:0]    col_q, col0, col_m1, col_s1;
	logic [POS_W-1:0] row_q, row0;
	logic [XW-1:0]    iw, w_eff, col_nx;
	logic [HW-1:0]    ih, h_eff, row_nx;
	logic             last_col, last_row, emit;
	logic [CW+POS_W-1:0] col_ext;
	logic [PIX_W-1:0] px0, old_rd, new_rd, top, mid;

	logic             v_s1, emit_s1, fe_s1, byp_s1;
	logic [POS_W-1:0] orow_s1, ocol_s1;
	logic [PIX_W-1:0] px_s1, bpold_s1, bpnew_s1;
	logic [5:0][PIX_W-1:0] win_q;

	assign px0  = {pixel.red_in, pixel.green_in, pixel.blue_in};
	assign col0 = pixel.frame_start ? '0 : col_q;
	assign row0 = pixel.frame_start ? '0 : row_q;

	always_comb begin
		iw = XW'(image_width);
		if (iw < XW'(MIN_DIM))
			w_eff = XW'(MIN_DIM);
		else if (iw > XW'(MAX_LINE_WIDTH))
			w_eff = XW'(MAX_LINE_WIDTH);
		else
			w_eff = iw;
		ih = HW'(image_height);
		if (ih < HW'(MIN_DIM))
			h_eff = HW'(MIN_DIM);
		else if (ih > HW'(MAX_HEIGHT))
			h_eff = HW'(MAX_HEIGHT);
		else
			h_eff = ih;
	end

	assign col_nx   = XW'(col0) + XW'(1);
	assign row_nx   = HW'(row0) + HW'(1);
	assign last_col = col_nx >= w_eff;
	assign last_row = row_nx >= h_eff;
	assign emit     = (row0 >= POS_W'(2)) && (col0 >= CW'(2));
	assign col_m1   = col0 - CW'(1);
	assign col_ext  = {{POS_W{1'b0}}, col_m1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row0 + POS_W'(1);
			end else begin
				col_q <= col0 + CW'(1);
				row_q <= row0;
			end
		end
	end

	rss_ram #(.WIDTH(PIX_W), .DEPTH(MAX_LINE_WIDTH)) u_older (
		.clk(clk), .we(v_s1), .waddr(col_s1), .wdata(mid),
		.re(accept), .raddr(col0), .rdata(old_rd)
	);

	rss_ram #(.WIDTH(PIX_W), .DEPTH(MAX_LINE_WIDTH)) u_newer (
		.clk(clk), .we(v_s1), .waddr(col_s1), .wdata(px_s1),
		.re(accept), .raddr(col0), .rdata(new_rd)
	);

	// same column as the word ahead: its store write lands after our read
	assign top = byp_s1 ? bpold_s1 : old_rd;
	assign mid = byp_s1 ? bpnew_s1 : new_rd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			emit_s1 <= 1'b0;
			byp_s1  <= 1'b0;
		end else begin
			v_s1    <= accept;
			emit_s1 <= accept && emit;
			if (accept)
				byp_s1 <= v_s1 && (col_s1 == col0);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			col_s1   <= col0;
			orow_s1  <= row0 - POS_W'(1);
			ocol_s1  <= col_ext[POS_W-1:0];
			fe_s1    <= last_row && last_col;
			px_s1    <= px0;
			bpold_s1 <= mid;
			bpnew_s1 <= px_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (v_s1) begin
			win_q[0] <= win_q[3];
			win_q[1] <= win_q[4];
			win_q[2] <= win_q[5];
			win_q[3] <= top;
			win_q[4] <= mid;
			win_q[5] <= px_s1;
		end
	end

	always_comb begin
		q_wr.push            = v_s1 && emit_s1;
		q_wr.entry.row       = orow_s1;
		q_wr.entry.col       = ocol_s1;
		q_wr.entry.frame_end = fe_s1;
		for (int k = 0; k < 6; k++)
			q_wr.entry.win[k] = win_q[k];
		q_wr.entry.win[6] = top;
		q_wr.entry.win[7] = mid;
		q_wr.entry.win[8] = px_s1;
	end

endmodule
`default_nettype wire

// File: hw/rtl/rss_queue.sv
// Short register queue between the front end and the stencil back end.
`default_nettype none
module rss_queue
	import rss_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire q_wr_t                      q_wr,
	input  wire logic                       q_pop,
	output q_rd_t                           q_rd,
	output logic [$clog2(DEPTH+1)-1:0]      count
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NW = $clog2(DEPTH + 1);

	q_entry_t        slot_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [NW-1:0]   cnt_q;
	logic            do_pop;

	assign do_pop       = q_pop && (cnt_q != '0);
	assign q_rd.valid   = cnt_q != '0;
	assign q_rd.entry   = slot_q[rd_ptr_q];
	assign count        = cnt_q;

	always_ff @(posedge clk) begin
		if (q_wr.push)
			slot_q[wr_ptr_q] <= q_wr.entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (q_wr.push)
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			if (q_wr.push && !do_pop)
				cnt_q <= cnt_q + NW'(1);
			else if (!q_wr.push && do_pop)
				cnt_q <= cnt_q - NW'(1);
		end
	end

endmodule
`default_nettype wire

// File: hw/rtl/rss_back.sv
// Back end: neighbor sums, 9x center minus neighbors, clamp, result register.
`default_nettype none
module rss_back
	import rss_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire q_rd_t   q_rd,
	output logic         q_pop,
	output result_t      result,
	output logic         empty,
	input  wire logic    pop
);

	logic    v_s1, v_out_q;
	sums_t   stg_s1;
	result_t res_q;
	logic    adv_out, adv_s1;

	assign adv_out = !v_out_q || pop;
	assign adv_s1  = !v_s1 || adv_out;
	assign q_pop   = q_rd.valid && adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_out_q <= 1'b0;
		end else begin
			if (adv_s1)
				v_s1 <= q_rd.valid;
			if (adv_out)
				v_out_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			stg_s1.row       <= q_rd.entry.row;
			stg_s1.col       <= q_rd.entry.col;
			stg_s1.frame_end <= q_rd.entry.frame_end;
			for (int ch = 0; ch < 3; ch++) begin
				stg_s1.center[ch] <= q_rd.entry.win[TAP_CENTER][ch*8 +: 8];
				stg_s1.nsum[ch]   <= nbr_sum(q_rd.entry.win, ch);
			end
		end
		if (v_s1 && adv_out) begin
			res_q.out_row   <= stg_s1.row;
			res_q.out_col   <= stg_s1.col;
			res_q.frame_end <= stg_s1.frame_end;
			res_q.red_out   <= sharpen_clamp(stg_s1.center[CH_RED], stg_s1.nsum[CH_RED]);
			res_q.green_out <= sharpen_clamp(stg_s1.center[CH_GREEN], stg_s1.nsum[CH_GREEN]);
			res_q.blue_out  <= sharpen_clamp(stg_s1.center[CH_BLUE], stg_s1.nsum[CH_BLUE]);
		end
	end

	assign result = res_q;
	assign empty  = !v_out_q;

endmodule
`default_nettype wire

// File: hw/rtl/rgb_sharpen_3x3_stencil.sv
// Top level of the streaming 3x3 RGB sharpen filter with its register port.
//
// Pixels arrive in raster order as words on a queue-style input: a word is
// taken at a clock edge with push high and full low; frame_start marks row 0,
// column 0. Each interior pixel leaves as one result word (row, column, the
// three sharpened channels, frame_end on the last interior pixel); border
// pixels give no word. Results are read like a queue: the oldest one sits on
// result while empty is low and is taken at an edge with pop high.
// image_width and image_height sit at byte addresses 0 and 4 of the APB port.
// Throughput is one pixel per cycle while full is low; a result is shown
// after the pixel below-right of its center is taken. Line store reads are
// registered in the front end; the back end adds a sum and a clamp stage.
// A short queue between the two halves lets the input keep flowing while the
// result side stalls; full rises once that queue and the word in flight
// fill it. Reset clears positions, window and queues; sizes go to 640x480.
// The line stores are not cleared.
`default_nettype none
module rgb_sharpen_3x3_stencil
	import rss_pkg::*;
#(
	parameter int MAX_LINE_WIDTH = MAX_LINE_WIDTH_DEF,
	parameter int QUEUE_DEPTH    = QUEUE_DEPTH_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	output logic                   full,
	input  wire pixel_t            pixel,
	output logic                   empty,
	input  wire logic              pop,
	output result_t                result,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [APB_AW-1:0] paddr,
	input  wire logic [APB_DW-1:0] pwdata,
	output logic      [APB_DW-1:0] prdata,
	output logic                   pready
);

	localparam int NW = $clog2(QUEUE_DEPTH + 1);

	logic [CFG_W-1:0] width_q, height_q;
	logic             accept, cfg_wr, q_pop;
	q_wr_t            q_wr;
	q_rd_t            q_rd;
	logic [NW-1:0]    q_count;
	logic [NW:0]      q_need;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_WIDTH:  width_q  <= pwdata[CFG_W-1:0];
				REG_HEIGHT: height_q <= pwdata[CFG_W-1:0];
				default:    ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_WIDTH:  prdata = {{(APB_DW-CFG_W){1'b0}}, width_q};
			REG_HEIGHT: prdata = {{(APB_DW-CFG_W){1'b0}}, height_q};
			default:    prdata = '0;
		endcase
	end

	assign q_need = {1'b0, q_count} + {{NW{1'b0}}, q_wr.push};
	assign full   = q_need >= (NW+1)'(QUEUE_DEPTH);
	assign accept = push && !full;

	rss_front #(.MAX_LINE_WIDTH(MAX_LINE_WIDTH)) u_front (
		.clk(clk), .arst_n(arst_n), .accept(accept), .pixel(pixel),
		.image_width(width_q), .image_height(height_q), .q_wr(q_wr)
	);

	rss_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk(clk), .arst_n(arst_n), .q_wr(q_wr), .q_pop(q_pop),
		.q_rd(q_rd), .count(q_count)
	);

	rss_back u_back (
		.clk(clk), .arst_n(arst_n), .q_rd(q_rd), .q_pop(q_pop),
		.result(result), .empty(empty), .pop(pop)
	);

	a_q_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_count <= NW'(QUEUE_DEPTH))
		else $error("queue count above depth");

	a_q_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_wr.push |-> (q_count < NW'(QUEUE_DEPTH) || q_pop))
		else $error("queue write while full");

	a_interior_pos: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (result.out_row != '0 && result.out_col != '0))
		else $error("result at a border position");

endmodule
`default_nettype wire
